// ===== hw/rtl/sabp_pkg.sv =====
package sabp_pkg;

  localparam int CHAN_W      = 8;
  localparam int N_CHAN      = 3;
  localparam int RGB_W       = CHAN_W * N_CHAN;
  localparam int PIX_W       = 32;
  localparam int POS_W       = 6;
  localparam int ORIGIN_W    = 12;
  localparam int SCROLL_W    = 9;
  localparam int ADDR_W      = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_ALPHA_MODE  = 3'd2,
    CFG_BLANK_KEY   = 3'd3,
    CFG_SCROLL_ROWS = 3'd4
  } cfg_reg_t;

  typedef logic [RGB_W-1:0] rgb_t;

endpackage

// ===== hw/rtl/sprite_alpha_blit_pixel.sv =====
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  col, line, sprite, mask, background
// m_axis    out        m_axis_tvalid/m_axis_tready  tuser write_enable; fb_address, color
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// Three register stages. One pixel per cycle is sustained while m_axis accepts results;
// the blend multipliers and the address multiplier each sit in their own stage.
// Synchronous reset clears all valid bits and the configuration registers.
// A stall on m_axis holds each full stage; empty stages ahead of it keep filling.
module sprite_alpha_blit_pixel
  import sabp_pkg::*;
#(
  parameter int SCREEN_WIDTH   = 1024,
  parameter int SCREEN_HEIGHT  = 768,
  parameter int MAX_SPRITE_DIM = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // col[5:0], line[11:6], sprite_pixel[43:12], mask_pixel[75:44],
  // background_pixel[107:76], zero fill above.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // fb_address[19:0], color_out[51:20], zero fill above.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // write_enable[0].
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W = ORIGIN_W + 1;
  localparam logic [SW_W-1:0] SW_C = SW_W'(SCREEN_WIDTH);

  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic                alpha_mode;
  logic [PIX_W-1:0]    blank_key;
  logic [SCROLL_W-1:0] scroll_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      alpha_mode  <= 1'b0;
      blank_key   <= '0;
      scroll_rows <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:    origin_x    <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:    origin_y    <= cfg_data[ORIGIN_W-1:0];
        CFG_ALPHA_MODE:  alpha_mode  <= cfg_data[0];
        CFG_BLANK_KEY:   blank_key   <= cfg_data[PIX_W-1:0];
        CFG_SCROLL_ROWS: scroll_rows <= cfg_data[SCROLL_W-1:0];
        default: ;
      endcase
    end
  end

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3 || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: screen position, sprite bounds and key match.
  logic [POS_W-1:0] in_col, in_line;
  logic [PIX_W-1:0] in_spr, in_msk, in_bg;
  logic [ROW_W-1:0] sx_in, sy_in;
  logic             pre_ok_in;

  assign in_col  = s_axis_tdata[5:0];
  assign in_line = s_axis_tdata[11:6];
  assign in_spr  = s_axis_tdata[43:12];
  assign in_msk  = s_axis_tdata[75:44];
  assign in_bg   = s_axis_tdata[107:76];

  assign sx_in = {origin_x[ORIGIN_W-1], origin_x} + ROW_W'(in_col);
  assign sy_in = {origin_y[ORIGIN_W-1], origin_y} + ROW_W'(in_line);
  assign pre_ok_in = (32'(in_col) < 32'(MAX_SPRITE_DIM))
                  && (32'(in_line) < 32'(MAX_SPRITE_DIM))
                  && !(alpha_mode ? (in_msk == blank_key) : (in_spr == blank_key));

  logic [ROW_W-1:0] sx1, sy1;
  logic             pre_ok1;
  logic [PIX_W-1:0] spr1, msk1, bg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sx1     <= sx_in;
      sy1     <= sy_in;
      pre_ok1 <= pre_ok_in;
      spr1    <= in_spr;
      msk1    <= in_msk;
      bg1     <= in_bg;
    end
  end

  // Stage 2: on-screen test, scrolled row, channel blend.
  logic             on_screen;
  logic [ROW_W-1:0] row_sum;

  assign on_screen = !sx1[ROW_W-1] && !sy1[ROW_W-1]
                  && (32'(sx1[ORIGIN_W-1:0]) < 32'(SCREEN_WIDTH))
                  && (32'(sy1[ORIGIN_W-1:0]) < 32'(SCREEN_HEIGHT));
  assign row_sum = ROW_W'(sy1[ORIGIN_W-1:0]) + ROW_W'(scroll_rows);

  logic                we2;
  logic [ROW_W-1:0]    row2;
  logic [ORIGIN_W-1:0] col2;
  logic [PIX_W-1:0]    spr2;
  rgb_t                mix2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      we2  <= pre_ok1 && on_screen;
      row2 <= row_sum;
      col2 <= sx1[ORIGIN_W-1:0];
      spr2 <= spr1;
    end
  end

  sabp_blend u_blend (
    .clk    (clk),
    .en     (rdy2),
    .bottom (bg1[RGB_W-1:0]),
    .top    (spr1[RGB_W-1:0]),
    .weight (msk1[23:16]),
    .mix    (mix2)
  );

  // Stage 3: framebuffer address and output register.
  logic [32:0]      addr_full;
  logic [PIX_W-1:0] color_sel;

  assign addr_full = 33'(SW_C * row2) + 33'(col2);
  assign color_sel = alpha_mode ? {{(PIX_W-RGB_W){1'b0}}, mix2} : spr2;

  logic              we3;
  logic [ADDR_W-1:0] addr3;
  logic [PIX_W-1:0]  color3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      we3    <= we2;
      addr3  <= we2 ? addr_full[ADDR_W-1:0] : '0;
      color3 <= we2 ? color_sel : '0;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tuser  = we3;
  assign m_axis_tdata  = {{(OUT_TDATA_W-ADDR_W-PIX_W){1'b0}}, color3, addr3};

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("skipped pixel carries nonzero address or color");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v3 |-> s_axis_tready)
    else $error("input not ready with empty output stage");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1)
    else $error("stage 1 item lost during stall");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy3 |=> v2 && v3)
    else $error("stage 2 item lost during stall");

endmodule

// ===== hw/rtl/sabp_blend.sv =====
module sabp_blend
  import sabp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  rgb_t              bottom,
  input  rgb_t              top,
  input  logic [CHAN_W-1:0] weight,
  output rgb_t              mix
);

  logic [CHAN_W:0] inv_weight;

  assign inv_weight = (CHAN_W+1)'(1 << CHAN_W) - {1'b0, weight};

  for (genvar ch = 0; ch < N_CHAN; ch++) begin : g_chan
    logic [2*CHAN_W:0] sum;

    assign sum = (2*CHAN_W+1)'(bottom[ch*CHAN_W +: CHAN_W] * inv_weight)
               + (2*CHAN_W+1)'(top[ch*CHAN_W +: CHAN_W] * weight);

    always_ff @(posedge clk) begin
      if (en) begin
        mix[ch*CHAN_W +: CHAN_W] <= sum[2*CHAN_W-1:CHAN_W];
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sabp_pkg::*;

  localparam int SCR_W   = 1024;
  localparam int SCR_H   = 768;
  localparam int MAX_DIM = 64;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  color;
  } fb_write_t;

  class blit_scoreboard;
    logic signed [ORIGIN_W-1:0] org_x;
    logic signed [ORIGIN_W-1:0] org_y;
    logic                       alpha;
    logic [PIX_W-1:0]           key;
    logic [SCROLL_W-1:0]        scroll;
    fb_write_t                  pending[$];
    int                         mismatches;
    int                         results;
    int                         writes;

    function new();
      org_x = '0;
      org_y = '0;
      alpha = 1'b0;
      key = '0;
      scroll = '0;
      mismatches = 0;
      results = 0;
      writes = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ORIGIN_X:    org_x = val[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:    org_y = val[ORIGIN_W-1:0];
        CFG_ALPHA_MODE:  alpha = val[0];
        CFG_BLANK_KEY:   key = val[PIX_W-1:0];
        CFG_SCROLL_ROWS: scroll = val[SCROLL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] bot, logic [CHAN_W-1:0] top,
                                    logic [CHAN_W-1:0] m);
      int acc;
      acc = int'(bot) * (256 - int'(m)) + int'(top) * int'(m);
      return acc[15:8];
    endfunction

    function fb_write_t overlay_pixel(logic [POS_W-1:0] px_col, logic [POS_W-1:0] px_row,
                                      logic [PIX_W-1:0] spr, logic [PIX_W-1:0] msk,
                                      logic [PIX_W-1:0] bg);
      fb_write_t  r;
      int         sx;
      int         sy;
      logic [31:0] a;
      logic       wr;
      logic [PIX_W-1:0] c;
      sx = org_x;
      sx = sx + int'(px_col);
      sy = org_y;
      sy = sy + int'(px_row);
      wr = sx >= 0 && sx < SCR_W && sy >= 0 && sy < SCR_H &&
           int'(px_col) < MAX_DIM && int'(px_row) < MAX_DIM;
      if (alpha) begin
        wr = wr && (msk != key);
        c = {8'h00, mix(bg[23:16], spr[23:16], msk[23:16]),
             mix(bg[15:8], spr[15:8], msk[23:16]), mix(bg[7:0], spr[7:0], msk[23:16])};
      end else begin
        wr = wr && (spr != key);
        c = spr;
      end
      a = SCR_W * (sy + int'(scroll)) + sx;
      r.we = wr;
      r.addr = wr ? a[ADDR_W-1:0] : '0;
      r.color = wr ? c : '0;
      return r;
    endfunction

    function void note_pixel(logic [POS_W-1:0] px_col, logic [POS_W-1:0] px_row,
                             logic [PIX_W-1:0] spr, logic [PIX_W-1:0] msk,
                             logic [PIX_W-1:0] bg);
      pending.push_back(overlay_pixel(px_col, px_row, spr, msk, bg));
    endfunction

    function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on %s: expected %h, got %h.", what, want_v, got_v);
    endfunction

    function void check_result(logic we, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] color);
      fb_write_t want;
      results++;
      if (we) writes++;
      if (pending.size() == 0) begin
        report("result with no pixel pending", '0, color);
      end else begin
        want = pending.pop_front();
        if (we !== want.we) report("write_enable", 32'(want.we), 32'(we));
        if (addr !== want.addr) report("fb_address", 32'(want.addr), 32'(addr));
        if (color !== want.color) report("color_out", want.color, color);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  blit_scoreboard sb = new();
  bit             calm;
  bit             hold_req;
  int             hold_left;
  int             stall_cycles;
  int             settings;

  always #2 clk = ~clk;

  sprite_alpha_blit_pixel dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  task automatic send_pixel(input logic [POS_W-1:0] px_col, input logic [POS_W-1:0] px_row,
                            input logic [PIX_W-1:0] spr, input logic [PIX_W-1:0] msk,
                            input logic [PIX_W-1:0] bg);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, bg, msk, spr, px_row, px_col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pixel(px_col, px_row, spr, msk, bg);
  endtask

  task automatic random_pixel();
    logic [PIX_W-1:0] spr;
    logic [PIX_W-1:0] msk;
    spr = $urandom;
    msk = $urandom;
    case ($urandom_range(9))
      0: msk[23:16] = 8'h00;
      1: msk[23:16] = 8'hff;
      default: ;
    endcase
    if ($urandom_range(9) == 0) begin
      if (sb.alpha) msk = sb.key;
      else spr = sb.key;
    end
    send_pixel(POS_W'($urandom_range(63)), POS_W'($urandom_range(63)), spr, msk, $urandom);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic signed [ORIGIN_W-1:0] ox,
                               input logic signed [ORIGIN_W-1:0] oy, input logic am,
                               input logic [PIX_W-1:0] key, input logic [SCROLL_W-1:0] scr);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(CFG_ORIGIN_X, 32'(ox));
    write_reg(CFG_ORIGIN_Y, 32'(oy));
    write_reg(CFG_ALPHA_MODE, 32'(am));
    write_reg(CFG_BLANK_KEY, key);
    write_reg(CFG_SCROLL_ROWS, 32'(scr));
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[ADDR_W-1:0],
                        m_axis_tdata[ADDR_W+PIX_W-1:ADDR_W]);
      if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(99) >= 13;
      end
    end
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int ox;
    int oy;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: copy mode, zero key, origin at the top-left corner.
    send_pixel(0, 0, 32'h0000_0000, 32'h1234_5678, 32'hffff_ffff);
    send_pixel(0, 0, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
    send_pixel(63, 63, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    send_pixel(63, 0, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff);
    send_pixel(0, 63, 32'h8000_0000, 32'h00ff_0000, 32'h0000_0000);
    send_pixel(21, 42, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555);

    // Blend mode near the bottom-right screen edge.
    apply_setting(1000, 740, 1'b1, 32'h00ff_00ff, 0);
    send_pixel(0, 0, 32'hffff_ffff, 32'h0000_0000, 32'h0012_3456);
    send_pixel(1, 0, 32'h00ff_ffff, 32'h00ff_0000, 32'h0000_0000);
    send_pixel(2, 1, 32'h0020_40ff, 32'hff80_0000, 32'h00ff_8010);
    send_pixel(3, 2, 32'h0011_2233, 32'h00ff_00ff, 32'h0044_5566);
    send_pixel(4, 3, 32'h00ff_00ff, 32'h0040_0000, 32'h0000_0000);
    send_pixel(23, 27, 32'h00ab_cdef, 32'h0080_0000, 32'h0010_2030);
    send_pixel(24, 27, 32'h00ab_cdef, 32'h0080_0000, 32'h0010_2030);
    send_pixel(23, 28, 32'h00ab_cdef, 32'h0080_0000, 32'h0010_2030);
    send_pixel(5, 5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: apply_setting(ORIGIN_W'(-2048), ORIGIN_W'(-2048), 1'b0, $urandom, 0);
        1: apply_setting(2047, 2047, 1'b1, $urandom, 256);
        2: apply_setting(960, 704, 1'b1, $urandom, 256);
        3: apply_setting(ORIGIN_W'(-32), ORIGIN_W'(-32), 1'b0, $urandom, 0);
        4: apply_setting(0, 0, 1'b1, 32'hffff_ffff, 255);
        default: begin
          ox = ($urandom_range(5) == 0) ? $urandom : int'($urandom_range(1100)) - 64;
          oy = ($urandom_range(5) == 0) ? $urandom : int'($urandom_range(830)) - 64;
          apply_setting(ORIGIN_W'(ox), ORIGIN_W'(oy), 1'($urandom_range(1)), $urandom,
                        SCROLL_W'($urandom_range(256)));
        end
      endcase
      calm = (ph == 2);
      if (ph == 5) hold_req = 1'b1;
      repeat (120) random_pixel();
    end

    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d pixels under %0d register settings: %0d written, %0d skipped.",
             sb.results, settings + 1, sb.writes, sb.results - sb.writes);
    $display("Input transfers were held back for %0d cycles; %0d mismatches found.",
             stall_cycles, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
